// ----- rtl/bdlp_pkg.sv -----
package bdlp_pkg;

    localparam int NBTN = 3;

    localparam logic [1:0] BTN_LEFT   = 2'd0;
    localparam logic [1:0] BTN_MIDDLE = 2'd1;
    localparam logic [1:0] BTN_RIGHT  = 2'd2;

    localparam int DEB_W  = 16;
    localparam int TIME_W = 20;
    localparam int CFG_W  = 20;

    localparam logic [DEB_W-1:0]  DEBOUNCE_RST   = 16'd50;
    localparam logic [TIME_W-1:0] LONG_PRESS_RST = 20'd1000;
    localparam logic [TIME_W-1:0] PAIRING_RST    = 20'd3000;
    localparam logic [TIME_W-1:0] BOND_RESET_RST = 20'd10000;

    typedef enum logic [2:0] {
        REG_DEBOUNCE   = 3'd0,
        REG_LONG_PRESS = 3'd1,
        REG_PAIRING    = 3'd2,
        REG_BOND_RESET = 3'd3
    } bdlp_reg_t;

    typedef enum logic [2:0] {
        EV_NONE        = 3'd0,
        EV_LEFT_SHORT  = 3'd1,
        EV_LEFT_LONG   = 3'd2,
        EV_MIDDLE_LONG = 3'd3,
        EV_RIGHT_SHORT = 3'd4,
        EV_RIGHT_LONG  = 3'd5,
        EV_PAIRING     = 3'd6,
        EV_BOND_RESET  = 3'd7
    } bdlp_event_t;

    // per-button outcome of one tick
    typedef struct packed {
        logic press;
        logic long_ev;
        logic short_ev;
        logic held;
    } bdlp_btn_ev_t;

    // chord controller to button stages
    typedef struct packed {
        logic run;
        logic clear;
    } bdlp_ctl_t;

    function automatic bdlp_event_t short_code(input logic [1:0] idx);
        bdlp_event_t c;
        unique case (idx)
            BTN_LEFT:  c = EV_LEFT_SHORT;
            BTN_RIGHT: c = EV_RIGHT_SHORT;
            default:   c = EV_NONE;
        endcase
        return c;
    endfunction

    function automatic bdlp_event_t long_code(input logic [1:0] idx);
        bdlp_event_t c;
        unique case (idx)
            BTN_LEFT:   c = EV_LEFT_LONG;
            BTN_MIDDLE: c = EV_MIDDLE_LONG;
            BTN_RIGHT:  c = EV_RIGHT_LONG;
            default:    c = EV_NONE;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/bdlp_button.sv -----
module bdlp_button
    import bdlp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic              clear,
    input  logic [31:0]       now,
    input  logic              raw,
    input  logic [DEB_W-1:0]  deb_time,
    input  logic [TIME_W-1:0] long_time,
    output bdlp_btn_ev_t      ev
);

    logic        prev_reg, prev_next;
    logic        held_reg, held_next;
    logic        long_reg, long_next;
    logic [31:0] bounce_reg, bounce_next;
    logic [31:0] press_reg, press_next;

    logic [31:0] bounce_upd;
    logic [31:0] press_upd;
    logic        stable;
    logic        pressed;
    logic        new_press;
    logic        held_upd;
    logic        long_upd;
    logic        long_hit;
    logic        short_hit;

    always_comb
    begin
        bounce_upd = (raw != prev_reg) ? now : bounce_reg;
        stable     = (now - bounce_upd) >= {{(32-DEB_W){1'b0}}, deb_time};
        pressed    = !raw;
        new_press  = stable && pressed && !held_reg;
        held_upd   = held_reg | new_press;
        long_upd   = new_press ? 1'b0 : long_reg;
        press_upd  = new_press ? now : press_reg;
        long_hit   = stable && pressed && held_upd && !long_upd &&
                     ((now - press_upd) >= {{(32-TIME_W){1'b0}}, long_time});
        short_hit  = stable && !pressed && held_reg && !long_reg;

        prev_next   = prev_reg;
        held_next   = held_reg;
        long_next   = long_reg;
        bounce_next = bounce_reg;
        press_next  = press_reg;
        if (clear)
        begin
            prev_next   = 1'b1;
            held_next   = 1'b0;
            long_next   = 1'b0;
            bounce_next = now;
        end
        else if (step)
        begin
            prev_next   = raw;
            bounce_next = bounce_upd;
            if (stable)
            begin
                held_next  = pressed;
                long_next  = long_upd | long_hit;
                press_next = press_upd;
            end
        end

        ev.press    = step && new_press;
        ev.long_ev  = step && long_hit;
        ev.short_ev = step && short_hit;
        ev.held     = held_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg   <= 1'b1;
            held_reg   <= 1'b0;
            long_reg   <= 1'b0;
            bounce_reg <= '0;
            press_reg  <= '0;
        end
        else
        begin
            prev_reg   <= prev_next;
            held_reg   <= held_next;
            long_reg   <= long_next;
            bounce_reg <= bounce_next;
            press_reg  <= press_next;
        end
    end

endmodule

// ----- rtl/bdlp_chord.sv -----
module bdlp_chord
    import bdlp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              tick,
    input  logic              read,
    input  logic              lp,
    input  logic              rp,
    input  logic [31:0]       now,
    input  logic [TIME_W-1:0] pairing_ms,
    input  logic [TIME_W-1:0] bond_reset_ms,
    input  bdlp_btn_ev_t      ev [NBTN],
    output bdlp_ctl_t         ctl,
    output logic              cancel,
    output bdlp_event_t       code,
    output logic              slot_empty
);

    logic        active_reg, active_next;
    logic        bond_reg, bond_next;
    logic [31:0] stamp_reg, stamp_next;
    bdlp_event_t pend_reg, pend_next;
    logic [31:0] elapsed;

    // buttons run only on ticks outside a chord; chord release clears them
    assign ctl.run   = tick && !active_reg && !(lp && rp);
    assign ctl.clear = tick && active_reg && !lp && !rp;

    always_comb
    begin
        active_next = active_reg;
        bond_next   = bond_reg;
        stamp_next  = stamp_reg;
        pend_next   = pend_reg;
        code        = EV_NONE;
        cancel      = 1'b0;
        elapsed     = '0;
        if (read)
        begin
            code      = pend_reg;
            pend_next = EV_NONE;
        end
        else if (tick)
        begin
            if (lp && rp && !active_reg)
            begin
                active_next = 1'b1;
                bond_next   = 1'b0;
                stamp_next  = now;
                cancel      = 1'b1;
                pend_next   = EV_NONE;
            end
            elapsed = now - stamp_next;
            if (active_next)
            begin
                if (lp && rp && !bond_next &&
                    elapsed >= {{(32-TIME_W){1'b0}}, bond_reset_ms})
                begin
                    pend_next = EV_BOND_RESET;
                    bond_next = 1'b1;
                end
                if (!lp && !rp)
                begin
                    if (!bond_next && elapsed >= {{(32-TIME_W){1'b0}}, pairing_ms})
                    begin
                        pend_next = EV_PAIRING;
                    end
                    active_next = 1'b0;
                end
            end
            else
            begin
                // later buttons overwrite earlier ones in the slot
                for (int i = 0; i < NBTN; i++)
                begin
                    if (ev[i].long_ev)
                    begin
                        pend_next = long_code(2'(i));
                    end
                    else if (ev[i].short_ev && short_code(2'(i)) != EV_NONE)
                    begin
                        pend_next = short_code(2'(i));
                    end
                end
                if (ev[BTN_MIDDLE].long_ev)
                begin
                    cancel = 1'b1;
                end
            end
        end
    end

    assign slot_empty = (pend_next == EV_NONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            bond_reg   <= 1'b0;
            stamp_reg  <= '0;
            pend_reg   <= EV_NONE;
        end
        else
        begin
            active_reg <= active_next;
            bond_reg   <= bond_next;
            stamp_reg  <= stamp_next;
            pend_reg   <= pend_next;
        end
    end

endmodule

// ----- rtl/button_debounce_long_press_chord_unit.sv -----
// Three-button debouncer with short/long press events and a left+right chord for
// pairing and bond reset. Each input beat is either a tick (tuser 0) carrying a
// wrapping millisecond timestamp and the raw active-low pin levels, or a read
// (tuser 1) that returns the one-entry pending event slot and clears it. Every
// beat yields exactly one output beat. A beat is taken into an input register,
// processed by compare logic against the button and chord state, and the result
// lands in an output register: one beat per clock when not stalled, and the input
// keeps flowing while a result waits as long as the output register is free or
// being drained. Configuration writes take effect at once and must be made while
// no beat is in flight.
module button_debounce_long_press_chord_unit
    import bdlp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [39:0]       s_tdata,   // now_ms[31:0], left_level, middle_level,
                                         // right_level, zero pad
    input  logic              s_tuser,   // command
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // event_code[2:0], middle_press_strobe,
                                         // middle_release_strobe, middle_cancel_strobe,
                                         // middle_held, slot_empty
    input  logic              cfg_we,
    input  logic [2:0]        cfg_addr,
    input  logic [CFG_W-1:0]  cfg_wdata
);

    logic [DEB_W-1:0]  debounce_reg;
    logic [TIME_W-1:0] long_press_reg;
    logic [TIME_W-1:0] pairing_reg;
    logic [TIME_W-1:0] bond_reset_reg;

    logic              in_valid_reg;
    logic              cmd_reg;
    logic [31:0]       now_reg;
    logic [NBTN-1:0]   lv_reg;

    logic              out_valid_reg;
    logic [7:0]        out_data_reg;

    logic              advance;
    logic              tick;
    logic              read;
    bdlp_ctl_t         ctl;
    bdlp_btn_ev_t      ev [NBTN];
    logic              cancel;
    bdlp_event_t       code;
    logic              slot_empty;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign tick     = advance && !cmd_reg;
    assign read     = advance && cmd_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= DEBOUNCE_RST;
            long_press_reg <= LONG_PRESS_RST;
            pairing_reg    <= PAIRING_RST;
            bond_reset_reg <= BOND_RESET_RST;
        end
        else if (cfg_we)
        begin
            unique case (bdlp_reg_t'(cfg_addr))
                REG_DEBOUNCE:   debounce_reg   <= cfg_wdata[DEB_W-1:0];
                REG_LONG_PRESS: long_press_reg <= cfg_wdata[TIME_W-1:0];
                REG_PAIRING:    pairing_reg    <= cfg_wdata[TIME_W-1:0];
                REG_BOND_RESET: bond_reset_reg <= cfg_wdata[TIME_W-1:0];
                default:        ;
            endcase
        end
    end

    // input register: hold the beat until the result register can take it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            cmd_reg <= s_tuser;
            now_reg <= s_tdata[31:0];
            lv_reg  <= s_tdata[34:32];
        end
    end

    for (genvar g = 0; g < NBTN; g++)
    begin : g_btn
        bdlp_button u_button (
            .clk       (clk),
            .rst_n     (rst_n),
            .step      (ctl.run),
            .clear     (ctl.clear),
            .now       (now_reg),
            .raw       (lv_reg[g]),
            .deb_time  (debounce_reg),
            .long_time (long_press_reg),
            .ev        (ev[g])
        );
    end

    bdlp_chord u_chord (
        .clk           (clk),
        .rst_n         (rst_n),
        .tick          (tick),
        .read          (read),
        .lp            (!lv_reg[BTN_LEFT]),
        .rp            (!lv_reg[BTN_RIGHT]),
        .now           (now_reg),
        .pairing_ms    (pairing_reg),
        .bond_reset_ms (bond_reset_reg),
        .ev            (ev),
        .ctl           (ctl),
        .cancel        (cancel),
        .code          (code),
        .slot_empty    (slot_empty)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= {slot_empty,
                             ev[BTN_MIDDLE].held,
                             cancel,
                             ev[BTN_MIDDLE].short_ev,
                             ev[BTN_MIDDLE].press,
                             code};
        end
    end

endmodule

// ----- rtl/bdlp_checker.sv -----
module bdlp_checker
    import bdlp_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [7:0]       m_tdata
);

    // event codes come only from reads, strobes only from ticks
    a_code_xor_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[5:3] != 3'b000) |-> (m_tdata[2:0] == EV_NONE))
        else $error("event code and strobe in the same beat");

    // a read that returns an event leaves the slot empty
    a_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[2:0] != EV_NONE) |-> m_tdata[7])
        else $error("slot not cleared by read");

    a_press_release_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[3] && m_tdata[4]))
        else $error("middle press and release in one beat");

    a_release_not_held: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[4]) |-> !m_tdata[6])
        else $error("middle still held after release");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled output beat changed");

endmodule

bind button_debounce_long_press_chord_unit bdlp_checker u_bdlp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- test/button_event_checker.sv -----
module button_event_checker
    import bdlp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [39:0]       s_tdata,   // now_ms[31:0], left_level, middle_level,
                                         // right_level, zero pad
    input  logic              s_tuser,   // command
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [7:0]        m_tdata,   // event_code[2:0], middle_press_strobe,
                                         // middle_release_strobe, middle_cancel_strobe,
                                         // middle_held, slot_empty
    input  logic              cfg_we,
    input  logic [2:0]        cfg_addr,
    input  logic [CFG_W-1:0]  cfg_wdata,
    output int                mismatches,
    output int                in_flight
);

    typedef struct packed {
        logic        empty;
        logic        held;
        logic        cancel;
        logic        rel;
        logic        press;
        bdlp_event_t code;
    } button_report_t;

    logic [DEB_W-1:0]  deb_cfg;
    logic [TIME_W-1:0] long_cfg;
    logic [TIME_W-1:0] pair_cfg;
    logic [TIME_W-1:0] bond_cfg;

    logic [NBTN-1:0] lvl_last;
    logic [NBTN-1:0] down;
    logic [NBTN-1:0] long_seen;
    logic [31:0]     settle_t [NBTN];
    logic [31:0]     press_t  [NBTN];
    logic            chord_on;
    logic            bond_fired;
    logic [31:0]     chord_t;
    bdlp_event_t     slot;

    button_report_t report_q [$];
    int             results_seen;

    initial mismatches = 0;

    task automatic flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= 40)
            $display("result beat %0d: %s", results_seen, what);
    endtask

    task automatic compare_field(input string field, input logic [2:0] got,
                                 input logic [2:0] want);
        if (got !== want)
            flag_mismatch($sformatf("%s got %0d, want %0d", field, got, want));
    endtask

    // Work out the report for one input beat and move the button and chord state on.
    task automatic advance_buttons(input logic cmd, input logic [31:0] now,
                                   input logic [2:0] lv, output button_report_t r);
        logic        lp;
        logic        rp;
        logic        pressed;
        logic [31:0] el;
        r = '0;
        if (cmd) begin
            r.code = slot;
            slot   = EV_NONE;
        end
        else begin
            lp = !lv[BTN_LEFT];
            rp = !lv[BTN_RIGHT];
            if (lp && rp && !chord_on) begin
                chord_on   = 1'b1;
                bond_fired = 1'b0;
                chord_t    = now;
                r.cancel   = 1'b1;
                slot       = EV_NONE;
            end
            if (chord_on) begin
                el = now - chord_t;
                if (lp && rp && !bond_fired && el >= bond_cfg) begin
                    slot       = EV_BOND_RESET;
                    bond_fired = 1'b1;
                end
                if (!lp && !rp) begin
                    if (!bond_fired && el >= pair_cfg)
                        slot = EV_PAIRING;
                    chord_on = 1'b0;
                    // chord release drops every button back to released
                    for (int i = 0; i < NBTN; i++)
                    begin
                        down[i]      = 1'b0;
                        long_seen[i] = 1'b0;
                        lvl_last[i]  = 1'b1;
                        settle_t[i]  = now;
                    end
                end
            end
            else begin
                for (int i = 0; i < NBTN; i++)
                begin
                    if (lv[i] != lvl_last[i])
                        settle_t[i] = now;
                    lvl_last[i] = lv[i];
                    el = now - settle_t[i];
                    if (el >= deb_cfg) begin
                        pressed = !lv[i];
                        if (pressed && !down[i]) begin
                            down[i]      = 1'b1;
                            press_t[i]   = now;
                            long_seen[i] = 1'b0;
                            if (i == BTN_MIDDLE)
                                r.press = 1'b1;
                        end
                        el = now - press_t[i];
                        if (pressed && down[i] && !long_seen[i] && el >= long_cfg) begin
                            long_seen[i] = 1'b1;
                            case (i)
                                BTN_LEFT:   slot = EV_LEFT_LONG;
                                BTN_MIDDLE:
                                begin
                                    slot     = EV_MIDDLE_LONG;
                                    r.cancel = 1'b1;
                                end
                                default:    slot = EV_RIGHT_LONG;
                            endcase
                        end
                        if (!pressed && down[i]) begin
                            // the middle button hands short presses to the outside
                            if (!long_seen[i]) begin
                                case (i)
                                    BTN_LEFT:   slot  = EV_LEFT_SHORT;
                                    BTN_MIDDLE: r.rel = 1'b1;
                                    default:    slot  = EV_RIGHT_SHORT;
                                endcase
                            end
                            down[i] = 1'b0;
                        end
                    end
                end
            end
        end
        r.held  = down[BTN_MIDDLE];
        r.empty = (slot == EV_NONE);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        button_report_t want;
        button_report_t fresh;
        if (!rst_n) begin
            deb_cfg    = DEBOUNCE_RST;
            long_cfg   = LONG_PRESS_RST;
            pair_cfg   = PAIRING_RST;
            bond_cfg   = BOND_RESET_RST;
            lvl_last   = '1;
            down       = '0;
            long_seen  = '0;
            for (int i = 0; i < NBTN; i++)
            begin
                settle_t[i] = '0;
                press_t[i]  = '0;
            end
            chord_on     = 1'b0;
            bond_fired   = 1'b0;
            chord_t      = '0;
            slot         = EV_NONE;
            results_seen = 0;
            report_q.delete();
            in_flight <= 0;
        end
        else begin
            if (m_tvalid && m_tready) begin
                if (report_q.size() == 0) begin
                    flag_mismatch("result beat with nothing expected");
                end
                else begin
                    want = report_q.pop_front();
                    compare_field("event_code", m_tdata[2:0], want.code);
                    compare_field("middle_press_strobe", m_tdata[3], want.press);
                    compare_field("middle_release_strobe", m_tdata[4], want.rel);
                    compare_field("middle_cancel_strobe", m_tdata[5], want.cancel);
                    compare_field("middle_held", m_tdata[6], want.held);
                    compare_field("slot_empty", m_tdata[7], want.empty);
                end
                results_seen++;
            end
            if (cfg_we) begin
                case (cfg_addr)
                    REG_DEBOUNCE:   deb_cfg  = cfg_wdata[DEB_W-1:0];
                    REG_LONG_PRESS: long_cfg = cfg_wdata[TIME_W-1:0];
                    REG_PAIRING:    pair_cfg = cfg_wdata[TIME_W-1:0];
                    REG_BOND_RESET: bond_cfg = cfg_wdata[TIME_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                advance_buttons(s_tuser, s_tdata[31:0], s_tdata[34:32], fresh);
                report_q.push_back(fresh);
            end
            in_flight <= in_flight + int'(s_tvalid && s_tready) - int'(m_tvalid && m_tready);
        end
    end

endmodule

// ----- test/tb_button_debounce_long_press_chord_unit.sv -----
module tb_button_debounce_long_press_chord_unit;
    import bdlp_pkg::*;

    localparam int         CYCLE_LIMIT = 400000;
    localparam logic       CMD_TICK    = 1'b0;
    localparam logic       CMD_READ    = 1'b1;
    localparam logic [2:0] REG_SPARE   = 3'd6;

    // pin levels {right, middle, left}, low means pressed
    localparam logic [2:0] ALL_UP  = 3'b111;
    localparam logic [2:0] L_DOWN  = 3'b110;
    localparam logic [2:0] M_DOWN  = 3'b101;
    localparam logic [2:0] R_DOWN  = 3'b011;
    localparam logic [2:0] LR_DOWN = 3'b010;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [39:0]       s_tdata;
    logic              s_tuser;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [7:0]        m_tdata;
    logic              cfg_we;
    logic [2:0]        cfg_addr;
    logic [CFG_W-1:0]  cfg_wdata;

    int          mismatches;
    int          in_flight;
    int          cycles = 0;
    int          items_sent;
    bit          steady;
    logic [31:0] now;
    int unsigned deb_set;
    int unsigned long_set;
    int unsigned pair_set;
    int unsigned bond_set;

    button_debounce_long_press_chord_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    button_event_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .mismatches (mismatches),
        .in_flight  (in_flight)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[button_debounce_long_press_chord_unit] ERROR");
            $finish;
        end
    end

    always @(posedge clk)
        m_tready <= steady || ($urandom_range(99) >= 29);

    task automatic send_beat(input logic cmd, input logic [31:0] stamp, input logic [2:0] lv);
        while (!steady && $urandom_range(99) < 29) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {5'b0, lv, stamp};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic tick(input logic [2:0] lv, input logic [31:0] delta);
        now = now + delta;
        send_beat(CMD_TICK, now, lv);
    endtask

    // stamp and levels are don't-care on a read, so scramble them
    task automatic read_slot();
        send_beat(CMD_READ, $urandom, 3'($urandom));
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (in_flight != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (addr)
            REG_DEBOUNCE:   deb_set  = value[DEB_W-1:0];
            REG_LONG_PRESS: long_set = value;
            REG_PAIRING:    pair_set = value;
            REG_BOND_RESET: bond_set = value;
            default: ;
        endcase
    endtask

    task automatic set_timing(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] lng,
                              input logic [CFG_W-1:0] pair, input logic [CFG_W-1:0] bond);
        write_reg(REG_DEBOUNCE, deb);
        write_reg(REG_LONG_PRESS, lng);
        write_reg(REG_PAIRING, pair);
        write_reg(REG_BOND_RESET, bond);
    endtask

    // Mostly steps of the order of the threshold at hand, now and then none or a huge jump.
    function automatic logic [31:0] pick_step(input int unsigned scale);
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 3)
            return $urandom;
        if (roll < 10)
            return 32'd0;
        return $urandom_range(scale, 0);
    endfunction

    task automatic hold_levels(input logic [2:0] lv, input int unsigned scale);
        repeat ($urandom_range(8, 2))
        begin
            if ($urandom_range(4) == 0)
                read_slot();
            tick(lv, pick_step(scale));
        end
    endtask

    task automatic play_gesture();
        int unsigned kind;
        int unsigned scale;
        logic [2:0]  lv;
        kind = $urandom_range(99);
        if (kind < 55) begin
            lv = ~(3'b001 << $urandom_range(2));
            if ($urandom_range(4) == 0)
                lv = 3'($urandom);
            // contact bounce ahead of the press
            if ($urandom_range(2) == 0)
                repeat ($urandom_range(3, 1))
                    tick(lv ^ 3'($urandom), $urandom_range(deb_set / 2));
            scale = (deb_set + ($urandom_range(1) ? long_set : long_set / 4)) / 3 + 1;
            hold_levels(lv, scale);
            repeat ($urandom_range(4, 1))
                tick(ALL_UP, pick_step(deb_set / 2 + 1));
        end
        else if (kind < 80) begin
            lv = LR_DOWN;
            lv[BTN_MIDDLE] = 1'($urandom);
            scale = ($urandom_range(1) ? bond_set : pair_set) / 3 + 1;
            hold_levels(lv, scale);
            // let go of one side first now and then
            if ($urandom_range(2) == 0)
                tick($urandom_range(1) ? L_DOWN : R_DOWN, pick_step(scale));
            lv = ALL_UP;
            lv[BTN_MIDDLE] = 1'($urandom);
            tick(lv, pick_step(scale));
            repeat ($urandom_range(3, 1))
                tick(ALL_UP, pick_step(deb_set / 2 + 1));
        end
        else if (kind < 90) begin
            repeat ($urandom_range(8, 3))
                tick(3'($urandom), pick_step(deb_set + 1));
        end
        else begin
            repeat ($urandom_range(3, 1))
                read_slot();
        end
        if ($urandom_range(1) == 0)
            read_slot();
    endtask

    initial
    begin
        int phase_end;
        s_tvalid  <= 1'b0;
        s_tuser   <= CMD_TICK;
        s_tdata   <= '0;
        cfg_we    <= 1'b0;
        cfg_addr  <= REG_DEBOUNCE;
        cfg_wdata <= '0;
        rst_n     <= 1'b0;
        now        = '0;
        steady     = 1'b0;
        items_sent = 0;
        deb_set    = DEBOUNCE_RST;
        long_set   = LONG_PRESS_RST;
        pair_set   = PAIRING_RST;
        bond_set   = BOND_RESET_RST;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed walk through the gestures at the reset timings
        read_slot();
        tick(ALL_UP, 0);
        tick(L_DOWN, 10);
        tick(L_DOWN, 60);
        tick(ALL_UP, 130);
        tick(ALL_UP, 60);
        read_slot();
        tick(M_DOWN, 40);
        tick(M_DOWN, 60);
        tick(M_DOWN, 1000);
        tick(ALL_UP, 100);
        tick(ALL_UP, 60);
        read_slot();
        tick(M_DOWN, 80);
        tick(M_DOWN, 60);
        tick(ALL_UP, 40);
        tick(ALL_UP, 60);
        tick(LR_DOWN, 100);
        tick(LR_DOWN, 10000);
        read_slot();
        tick(ALL_UP, 50);
        tick(LR_DOWN, 100);
        tick(ALL_UP, 3000);
        read_slot();
        now = 32'hFFFF_FFFF;
        send_beat(CMD_TICK, now, ALL_UP);
        send_beat(CMD_READ, 32'hFFFF_FFFF, 3'b000);

        for (int phase = 0; phase < 8; phase++)
        begin
            wait_for_results();
            case (phase)
                0: set_timing('0, '0, '0, '0);
                1: set_timing(20'h0FFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
                2:
                begin
                    set_timing(CFG_W'(DEBOUNCE_RST), CFG_W'(LONG_PRESS_RST),
                               CFG_W'(PAIRING_RST), CFG_W'(BOND_RESET_RST));
                    write_reg(REG_SPARE, '1);
                end
                default: set_timing(CFG_W'($urandom_range(20)),
                                    CFG_W'($urandom_range(300, 5)),
                                    CFG_W'($urandom_range(600, 10)),
                                    CFG_W'($urandom_range(1500, 50)));
            endcase
            steady = (phase == 4);
            phase_end = items_sent + ((phase == 1) ? 150 : 205);
            while (items_sent < phase_end)
                play_gesture();
        end

        wait_for_results();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && in_flight == 0)
            $display("[button_debounce_long_press_chord_unit] OK");
        else
            $display("[button_debounce_long_press_chord_unit] ERROR");
        $finish;
    end

endmodule
